FILE: rtl/core/jlsr_pkg.sv
// ----------------------------------------------------------------------------
// jlsr_pkg
// Shared types and constants of the speed ramp generator.
// ----------------------------------------------------------------------------
package jlsr_pkg;

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdSet   = 2'd1;
  localparam logic [1:0] CmdPlan  = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  localparam logic [2:0] RegJerk    = 3'd0;
  localparam logic [2:0] RegCeil    = 3'd1;
  localparam logic [2:0] RegFrame   = 3'd2;
  localparam logic [2:0] RegPosMax  = 3'd3;
  localparam logic [2:0] RegPosMin  = 3'd4;
  localparam logic [2:0] RegNegMax  = 3'd5;
  localparam logic [2:0] RegNegMin  = 3'd6;
  localparam logic [2:0] RegMode    = 3'd7;

  localparam logic signed [31:0] AccelReset = 32'sd655360;
  localparam logic signed [31:0] I32Max = 32'sh7fffffff;
  localparam logic signed [31:0] I32Min = 32'sh80000000;

  // input word: command, step_interval, new_target, speedup, slowdown
  typedef struct packed {
    logic [15:0]        slowdown_length;
    logic [15:0]        speedup_length;
    logic signed [31:0] new_target;
    logic [15:0]        step_interval;
    logic [1:0]         command;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] accel_goal;
    logic signed [31:0] accel_now;
    logic signed [31:0] speed_goal;
    logic signed [31:0] speed_now;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return I32Max;
    if (v < -34'sd2147483648) return I32Min;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/core/jerk_limited_speed_ramp_core.sv
// ----------------------------------------------------------------------------
// jerk_limited_speed_ramp_core
// Jerk limited speed ramp generator with a shared shift-add unit.
// ----------------------------------------------------------------------------
// Usage: one command word enters on the s_axis group (command, dt, target,
// section lengths); each command gives one result word on m_axis holding
// speed, target speed, acceleration and target acceleration.
// Configuration is written on cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Work per command: tick runs two 16-step shift-add multiplies on the one
// shared adder, only the first when the speed is already at its target and
// none with ramping off; plan runs one 16-step multiply and a 56-step
// restoring divide on the same adder, skips the divide with a zero divisor
// and does neither when skipped; set and clear need no arithmetic.
// Throughput is one command at a time; s_axis_tready is low while busy
// and while a result waits. The output register holds the result until
// m_axis_tready; the next command can be taken in the cycle after that.
// Reset restores the configuration defaults, speed 0, target 0 and both
// accelerations to 10.0; the block is ready right after reset.
// ----------------------------------------------------------------------------
module jerk_limited_speed_ramp_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], step_interval[17:2], new_target[49:18],
  // speedup_length[65:50], slowdown_length[81:66], zero pad to 88
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // speed_now, speed_goal, accel_now, accel_goal, 32 bits each from bit 0
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import jlsr_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul   = 4'd1;
  localparam logic [3:0] StSlew  = 4'd2;
  localparam logic [3:0] StSpd   = 4'd3;
  localparam logic [3:0] StSpdFin= 4'd4;
  localparam logic [3:0] StPlan  = 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;
  localparam logic [3:0] StPlanFin = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StDivFin = 4'd9;

  // configuration
  logic [30:0]        jerk_q;
  logic signed [31:0] ceil_q, pmax_q, pmin_q, nmax_q, nmin_q;
  logic [15:0]        frame_q;
  logic [1:0]         mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_q  <= 31'd576716800;
      ceil_q  <= 32'sd13107200;
      frame_q <= 16'd2185;
      pmax_q  <= 32'sd6553600;
      pmin_q  <= 32'sd0;
      nmax_q  <= -32'sd65536;
      nmin_q  <= -32'sd3276800;
      mode_q  <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegJerk:   jerk_q  <= cfg_data_i[30:0];
        RegCeil:   ceil_q  <= cfg_data_i;
        RegFrame:  frame_q <= cfg_data_i[15:0];
        RegPosMax: pmax_q  <= cfg_data_i;
        RegPosMin: pmin_q  <= cfg_data_i;
        RegNegMax: nmax_q  <= cfg_data_i;
        RegNegMin: nmin_q  <= cfg_data_i;
        RegMode:   mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  in_word_t in_w;
  assign in_w = in_word_t'(s_axis_tdata[81:0]);

  logic [3:0]         st_q;
  logic signed [31:0] spd_q, gspd_q, acc_q, gacc_q;
  logic [15:0]        dt_q, mulb_q;     // multiplier operand (shifted right)
  logic [5:0]         cnt_q;
  logic [63:0]        mcand_q;          // shifted multiplicand (magnitude)
  logic [63:0]        acc64_q;          // shift-add accumulator
  logic               neg_q;            // product sign
  logic               mul_slew_q;       // multiply is for slew step
  logic [15:0]        upl_q, dnl_q;
  logic [31:0]        tm_q;             // plan divisor
  logic [55:0]        rem_q;            // divide partial remainder
  logic [55:0]        quo_q;
  logic [31:0]        mag_q;
  logic               gneg_q;
  logic               ovalid_q;

  // shared adder
  logic [63:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  logic signed [33:0] slew_up, slew_dn;
  logic signed [31:0] a_new;
  logic signed [33:0] gap;
  logic signed [33:0] sp_sum;
  logic signed [31:0] sp_sat;
  logic signed [63:0] prod_s;
  logic signed [31:0] flr;
  logic signed [31:0] tgt_c;
  logic signed [33:0] tdiff;
  logic signed [31:0] q32, g_cl;
  logic [55:0] div_sh;

  assign div_sh = {rem_q[54:0], quo_q[55]};

  always_comb begin
    add_a = acc64_q;
    add_b = mulb_q[0] ? mcand_q : 64'd0;
    if (st_q == StDiv) begin
      // trial subtract of the divisor from the shifted remainder
      add_a = {8'd0, div_sh};
      add_b = {32'hffffffff, ~tm_q} + 64'd1;
    end
  end

  always_comb begin
    slew_up = 34'(acc_q) + 34'($signed({1'b0, acc64_q[47:16]}));
    slew_dn = 34'(acc_q) - 34'($signed({1'b0, acc64_q[47:16]}));
    if (gacc_q > acc_q) a_new = (slew_up > 34'(gacc_q)) ? gacc_q : slew_up[31:0];
    else                a_new = (slew_dn < 34'(gacc_q)) ? gacc_q : slew_dn[31:0];
    // product of accel magnitude and dt, floor divide by 2^16
    prod_s = neg_q ? -$signed(acc64_q) : $signed(acc64_q);
    flr    = 32'(prod_s >>> 16);
    sp_sum = 34'(spd_q) + 34'(flr);
    sp_sat = sat32(sp_sum);
    gap    = 34'(gspd_q) - 34'(spd_q);
    tgt_c  = (in_w.new_target > ceil_q) ? ceil_q : in_w.new_target;
    tdiff  = 34'(tgt_c) - 34'(spd_q);
    if (tm_q == 32'd0) begin
      q32 = gneg_q ? I32Min : ((mag_q != 32'd0) ? I32Max : 32'sd0);
    end else if (!gneg_q) begin
      q32 = (quo_q > 56'd2147483647) ? I32Max : quo_q[31:0];
    end else begin
      q32 = (quo_q > 56'd2147483648) ? I32Min : -quo_q[31:0];
    end
    g_cl = q32;
    if (!q32[31]) begin
      if (pmax_q > 0 && g_cl > pmax_q) g_cl = pmax_q;
      if (pmin_q > 0 && g_cl < pmin_q) g_cl = pmin_q;
    end else begin
      if (nmax_q < 0 && g_cl > nmax_q) g_cl = nmax_q;
      if (nmin_q < 0 && g_cl < nmin_q) g_cl = nmin_q;
    end
  end

  logic in_acc, out_acc;
  assign s_axis_tready = (st_q == StIdle) && !ovalid_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ovalid_q <= 1'b0;
      spd_q <= '0; gspd_q <= '0; acc_q <= AccelReset; gacc_q <= AccelReset;
      dt_q <= '0; mulb_q <= '0; cnt_q <= '0; mcand_q <= '0; acc64_q <= '0;
      neg_q <= 1'b0; mul_slew_q <= 1'b0; upl_q <= '0; dnl_q <= '0;
      tm_q <= '0; rem_q <= '0; quo_q <= '0; mag_q <= '0; gneg_q <= 1'b0;
    end else begin
      if (out_acc) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: if (in_acc) begin
          dt_q  <= in_w.step_interval;
          upl_q <= in_w.speedup_length;
          dnl_q <= in_w.slowdown_length;
          unique case (in_w.command)
            CmdTick: begin
              if (!mode_q[0]) begin
                spd_q <= gspd_q; st_q <= StOut;
              end else begin
                mcand_q <= {33'd0, jerk_q}; mulb_q <= in_w.step_interval;
                acc64_q <= '0; cnt_q <= 6'd16; neg_q <= 1'b0;
                mul_slew_q <= 1'b1; st_q <= StMul;
              end
            end
            CmdSet: begin
              gspd_q <= tgt_c;
              if ((tdiff > 0 && acc_q < 0) || (tdiff < 0 && acc_q > 0)) begin
                gacc_q <= (gacc_q == I32Min) ? I32Max : -gacc_q;
                acc_q  <= (acc_q == I32Min) ? I32Max : -acc_q;
              end
              st_q <= StOut;
            end
            CmdPlan: st_q <= (mode_q == 2'd3 && !(gspd_q == 0 && spd_q == 0))
                             ? StPlan : StOut;
            default: begin
              acc_q <= '0; gacc_q <= '0; st_q <= StOut;
            end
          endcase
        end
        StMul: begin
          acc64_q <= add_s;
          mcand_q <= mcand_q << 1;
          mulb_q  <= mulb_q >> 1;
          cnt_q   <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) st_q <= mul_slew_q ? StSlew : StPlanFin;
        end
        StSlew: begin
          acc_q <= a_new;
          if (spd_q == gspd_q) st_q <= StOut;
          else begin
            mcand_q <= {32'd0, a_new[31] ? (~a_new + 32'd1) : a_new};
            neg_q <= a_new[31]; mulb_q <= dt_q; acc64_q <= '0;
            cnt_q <= 6'd16; mul_slew_q <= 1'b0; st_q <= StSpd;
          end
        end
        StSpd: begin
          acc64_q <= add_s;
          mcand_q <= mcand_q << 1;
          mulb_q  <= mulb_q >> 1;
          cnt_q   <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) st_q <= StSpdFin;
        end
        StSpdFin: begin
          if (acc_q != 0 && ((34'(sp_sat) - 34'(gspd_q) >= 0 && acc_q > 0) ||
                             (34'(sp_sat) - 34'(gspd_q) <= 0 && acc_q < 0)))
            spd_q <= gspd_q;
          else spd_q <= sp_sat;
          st_q <= StOut;
        end
        StPlan: begin
          // time = len * frame_period on the shared adder
          mcand_q <= {48'd0, frame_q};
          mulb_q  <= (gspd_q >= spd_q) ? upl_q : dnl_q;
          acc64_q <= '0; cnt_q <= 6'd16; mul_slew_q <= 1'b0;
          gneg_q  <= gap < 0;
          mag_q   <= gap < 0 ? 32'(-gap) : 32'(gap);
          st_q    <= StMul;
        end
        StPlanFin: begin
          tm_q  <= acc64_q[31:0];
          rem_q <= '0; quo_q <= {mag_q, 24'd0};
          cnt_q <= 6'd56;
          st_q  <= (acc64_q[31:0] == 32'd0) ? StDivFin : StDiv;
        end
        StDiv: begin
          // one restoring step per cycle: dividend bits shift in from quo_q
          if (!add_s[63]) begin
            rem_q <= add_s[55:0];
            quo_q <= {quo_q[54:0], 1'b1};
          end else begin
            rem_q <= div_sh;
            quo_q <= {quo_q[54:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) st_q <= StDivFin;
        end
        StDivFin: begin
          gacc_q <= g_cl; st_q <= StOut;
        end
        StOut: if (!ovalid_q) begin
          ovalid_q <= 1'b1; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  out_word_t ow;
  assign ow.speed_now = spd_q;
  assign ow.speed_goal = gspd_q;
  assign ow.accel_now = acc_q;
  assign ow.accel_goal = gacc_q;
  assign m_axis_tdata = ow;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !ovalid_q || $past(ovalid_q)) else $error("result without work");
endmodule

FILE: dv/jerk_limited_speed_ramp_core_tb.sv
// ----------------------------------------------------------------------------
// jerk_limited_speed_ramp_core_tb
// Streams random and directed ramp commands through the core, predicts the
// four state values of every command in a scoreboard and compares each word.
// ----------------------------------------------------------------------------
module jerk_limited_speed_ramp_core_tb;
  import jlsr_pkg::*;

  class ramp_scoreboard;
    logic [30:0] jerk;
    logic signed [31:0] ceil_v, pos_max, pos_min, neg_max, neg_min;
    logic [15:0] frame;
    logic [1:0] mode;
    logic signed [31:0] spd, goal_spd, acc, goal_acc;
    out_word_t pending[$];
    int errors;
    int checked;

    function void reset_state();
      jerk = 31'd576716800; ceil_v = 13107200; frame = 16'd2185;
      pos_max = 6553600; pos_min = 0; neg_max = -65536; neg_min = -3276800;
      mode = 2'd3; spd = 0; goal_spd = 0; acc = AccelReset; goal_acc = AccelReset;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        RegJerk:   jerk = d[30:0];
        RegCeil:   ceil_v = d;
        RegFrame:  frame = d[15:0];
        RegPosMax: pos_max = d;
        RegPosMin: pos_min = d;
        RegNegMax: neg_max = d;
        RegNegMin: neg_min = d;
        default:   mode = d[1:0];
      endcase
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return I32Max;
      if (v < -64'sd2147483648) return I32Min;
      return v[31:0];
    endfunction

    function int sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function void tick(logic [15:0] dt);
      longint slew, a, p, inc;
      if (!mode[0]) begin
        spd = goal_spd;
        return;
      end
      slew = longint'({33'd0, jerk} * {48'd0, dt}) >>> 16;
      if (goal_acc > acc) begin
        a = longint'(acc) + slew;
        if (a > goal_acc) a = goal_acc;
      end else begin
        a = longint'(acc) - slew;
        if (a < goal_acc) a = goal_acc;
      end
      acc = a[31:0];
      if (spd == goal_spd) return;
      p = a * longint'({48'd0, dt});
      inc = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
      spd = clip32(longint'(spd) + inc);
      if (a != 0 && sgn(longint'(spd) - goal_spd) * sgn(a) >= 0) spd = goal_spd;
    endfunction

    function void set_target(logic signed [31:0] t);
      if (t > ceil_v) t = ceil_v;
      goal_spd = t;
      if (sgn(longint'(t) - spd) * sgn(acc) < 0) begin
        goal_acc = clip32(-longint'(goal_acc));
        acc = clip32(-longint'(acc));
      end
    endfunction

    function void plan(logic [15:0] up_len, logic [15:0] down_len);
      longint gap, q;
      logic [63:0] tm, mag, uq;
      logic signed [31:0] g;
      if (mode != 2'd3) return;
      if (goal_spd == 0 && spd == 0) return;
      tm = ((goal_spd >= spd) ? up_len : down_len) * 64'(frame);
      gap = longint'(goal_spd) - spd;
      mag = (gap < 0) ? -gap : gap;
      if (tm == 0)
        q = (gap > 0) ? longint'(I32Max) : ((gap < 0) ? longint'(I32Min) : 0);
      else begin
        uq = (mag << 24) / tm;
        if (gap >= 0) q = (uq > 64'd2147483647) ? longint'(I32Max) : longint'(uq);
        else q = (uq > 64'd2147483648) ? longint'(I32Min) : -longint'(uq);
      end
      g = q[31:0];
      if (g >= 0) begin
        if (pos_max > 0 && g > pos_max) g = pos_max;
        if (pos_min > 0 && g < pos_min) g = pos_min;
      end else begin
        if (neg_max < 0 && g > neg_max) g = neg_max;
        if (neg_min < 0 && g < neg_min) g = neg_min;
      end
      goal_acc = g;
    endfunction

    function void note_command(in_word_t w);
      out_word_t r;
      case (w.command)
        CmdTick: tick(w.step_interval);
        CmdSet:  set_target(w.new_target);
        CmdPlan: plan(w.speedup_length, w.slowdown_length);
        default: begin
          acc = 0;
          goal_acc = 0;
        end
      endcase
      r.speed_now = spd; r.speed_goal = goal_spd;
      r.accel_now = acc; r.accel_goal = goal_acc;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got[31:0], 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.speed_now !== want.speed_now) report("speed_now", got.speed_now, want.speed_now);
      if (got.speed_goal !== want.speed_goal)
        report("speed_goal", got.speed_goal, want.speed_goal);
      if (got.accel_now !== want.accel_now) report("accel_now", got.accel_now, want.accel_now);
      if (got.accel_goal !== want.accel_goal)
        report("accel_goal", got.accel_goal, want.accel_goal);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [127:0] m_axis_tdata;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  ramp_scoreboard sb;
  int idle_cycles = 0;
  int sent;
  bit drain_on;

  jerk_limited_speed_ramp_core dut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  initial begin
    int stall;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gap_len();
      if (drain_on || $urandom_range(0, 3) != 0 || stall == 0) m_axis_tready <= 1;
      else begin
        m_axis_tready <= 0;
        repeat (stall) @(negedge clk_i);
        m_axis_tready <= 1;
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout, no traffic");
      $display("FAILURE");
      $finish;
    end
  end

  task send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata <= {6'd0, w};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(w);
    sent++;
    @(negedge clk_i);
  endtask

  task wait_drained();
    s_axis_tvalid <= 0;
    drain_on = 1;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    drain_on = 0;
  endtask

  task write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= d;
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  function in_word_t make_cmd(logic [1:0] c);
    in_word_t w;
    w.command = c;
    w.step_interval = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
    case ($urandom_range(0, 5))
      0:       w.new_target = $urandom;
      1:       w.new_target = -$signed(32'($urandom_range(0, 13107200)));
      default: w.new_target = $urandom_range(0, 13107200);
    endcase
    w.speedup_length = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    w.slowdown_length = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    return w;
  endfunction

  task random_phase(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_word(make_cmd(CmdTick));
      else if (r < 70) send_word(make_cmd(CmdSet));
      else if (r < 93) send_word(make_cmd(CmdPlan));
      else send_word(make_cmd(CmdClear));
    end
  endtask

  task random_cfg();
    write_cfg(RegJerk, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1 << 30));
    write_cfg(RegCeil, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 20000000));
    write_cfg(RegFrame, $urandom_range(0, 65535));
    write_cfg(RegPosMax, $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 10000000));
    write_cfg(RegPosMin, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000));
    write_cfg(RegNegMax, $urandom_range(0, 5) == 0 ? $urandom : -$urandom_range(0, 100000));
    write_cfg(RegNegMin, $urandom_range(0, 5) == 0 ? $urandom : -$urandom_range(0, 10000000));
    write_cfg(RegMode, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 3);
  endtask

  initial begin
    in_word_t w;
    sb = new();
    sb.reset_state();
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    sent = 0; drain_on = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: plan with both speeds zero, extremes, zero divisors
    w = '0; w.command = CmdPlan; w.speedup_length = 16'hffff; send_word(w);
    w = '0; w.command = CmdTick; w.step_interval = 16'hffff; send_word(w);
    w = '0; w.command = CmdSet; w.new_target = I32Max; send_word(w);
    w = '0; w.command = CmdPlan; send_word(w);
    w = '0; w.command = CmdTick; w.step_interval = 16'hffff; send_word(w);
    w = '0; w.command = CmdTick; w.step_interval = 16'hffff; send_word(w);
    w = '0; w.command = CmdSet; w.new_target = I32Min; send_word(w);
    w = '0; w.command = CmdPlan; w.speedup_length = 16'hffff;
    w.slowdown_length = 16'h0001; send_word(w);
    w = '0; w.command = CmdTick; w.step_interval = 16'h8000; send_word(w);
    w = '0; w.command = CmdTick; send_word(w);
    w = '0; w.command = CmdClear; send_word(w);
    w = '0; w.command = CmdTick; w.step_interval = 16'h1234; send_word(w);
    w = '0; w.command = CmdSet; w.new_target = 32'sd65536; send_word(w);
    w = '0; w.command = CmdPlan; w.slowdown_length = 16'hffff; send_word(w);
    wait_drained();

    // extremes: sign flip of most negative accel, ramp off, planning off
    write_cfg(RegJerk, 32'h7fffffff);
    write_cfg(RegCeil, 32'h7fffffff);
    write_cfg(RegFrame, 32'd0);
    write_cfg(RegPosMax, 32'd0);
    write_cfg(RegPosMin, 32'd0);
    write_cfg(RegNegMax, 32'd0);
    write_cfg(RegNegMin, 32'd0);
    write_cfg(RegMode, 32'd3);
    w = '0; w.command = CmdSet; w.new_target = -32'sd100; send_word(w);
    w = '0; w.command = CmdPlan; send_word(w);
    w = '0; w.command = CmdTick; w.step_interval = 16'hffff; send_word(w);
    w = '0; w.command = CmdSet; w.new_target = I32Max; send_word(w);
    wait_drained();
    write_cfg(RegMode, 32'd0);
    random_phase(20);
    wait_drained();
    write_cfg(RegMode, 32'd1);
    random_phase(20);
    wait_drained();
    write_cfg(RegMode, 32'd2);
    random_phase(20);
    wait_drained();

    repeat (9) begin
      random_cfg();
      random_phase(208);
      wait_drained();
    end

    $display("ran %0d commands over several register settings, %0d words checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: jerk_limited_speed_ramp_core.f
rtl/core/jlsr_pkg.sv
rtl/core/jerk_limited_speed_ramp_core.sv
dv/jerk_limited_speed_ramp_core_tb.sv
